FILE: rtl/core/imm_pkg.sv
`timescale 1ns / 1ps
// imm_pkg: shared types and constants of the integer matrix multiply unit
// no dependencies; imported by the mac unit and the top level, payload types fill the stream interface

package imm_pkg;

	// element and result data width
	localparam int DATA_W = 32;
	// configuration register width and register index width
	localparam int CFG_W  = 4;
	localparam int CFG_IDX_W = 2;
	// width of the row and column index fields on the result channel
	localparam int POS_W  = 3;

	typedef enum logic [1:0] {
		MODE_LOAD_A  = 2'd0,
		MODE_LOAD_B  = 2'd1,
		MODE_PRODUCT = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_MISMATCH   = 2'd1,
		STATUS_NOT_LOADED = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_A_ROWS = 2'd0,
		CFG_A_COLS = 2'd1,
		CFG_B_ROWS = 2'd2,
		CFG_B_COLS = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		mode_t                     mode;
		logic signed [DATA_W-1:0]  element_value;
	} cmd_payload_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  product_value;
		logic [POS_W-1:0]          row_index;
		logic [POS_W-1:0]          col_index;
		logic                      last_element;
		status_t                   status;
	} res_payload_t;

	// sequencer to mac unit
	typedef struct packed {
		logic clear;
		logic issue;
	} mac_ctrl_t;

	// mac unit to sequencer
	typedef struct packed {
		logic busy;
	} mac_stat_t;

endpackage

FILE: rtl/core/imm_stream_if.sv
`timescale 1ns / 1ps
// imm_stream_if: valid/ready stream channel carrying one payload type
// no dependencies; payload types come from imm_pkg at the instance

interface imm_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/integer_matrix_multiply_unit.sv
`timescale 1ns / 1ps
// integer_matrix_multiply_unit: top level, loads A and B, returns product elements
// depends on imm_pkg, imm_stream_if, imm_ram, imm_mac
//
// channel    dir  handshake            payload
// cmd        in   cmd.valid/cmd.ready  mode, element_value
// res        out  res.valid/res.ready  product_value, row_index, col_index,
//                                      last_element, status
// cfg        in   cfg_we               cfg_index, cfg_data
//
// a load is written to its store when accepted; a product request with a bad status
// skips to the result; a good request makes one memory read per term
// feeding the shared multiplier, then the read/multiply/add pipeline drains
// reset clears sizes to 2 and all load and position counters; stores need no clearing
// cmd is held off while a request is in flight or its result cannot enter res

module integer_matrix_multiply_unit import imm_pkg::*; #(
	parameter int MAX_DIM = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	imm_stream_if.sink           cmd,
	imm_stream_if.source         res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int IDX_W  = $clog2(MAX_DIM);
	localparam int DIM_W  = $clog2(MAX_DIM + 1);

	// size registers
	logic [CFG_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic [DIM_W-1:0] ar, ac, br, bc;

	// load pointers and product position
	logic [DIM_W-1:0] a_lr_q, b_lr_q;
	logic [IDX_W-1:0] a_lc_q, b_lc_q;
	logic [IDX_W-1:0] next_row_q, next_col_q;
	logic [IDX_W-1:0] k_q;

	seq_state_t state_q, state_d;
	status_t    status_q, status_d;

	logic         out_valid_q;
	res_payload_t out_q;

	logic              cmd_acc;
	logic              a_full, b_full;
	logic              load_a, load_b;
	logic              prod_req;
	logic              k_last;
	logic              res_free;
	logic              res_load;
	logic              pos_last;
	logic              col_wrap;
	mac_ctrl_t         mac_ctrl;
	mac_stat_t         mac_stat;
	logic [DATA_W-1:0] a_rdata, b_rdata, acc;
	logic [ADDR_W-1:0] a_waddr, b_waddr, a_raddr, b_raddr;

	// sizes below 2 act as 2, above MAX_DIM act as MAX_DIM
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (int'(v) < 2) begin
			r = DIM_W'(2);
		end else if (int'(v) > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

	assign ar = clamp_dim(a_rows_q);
	assign ac = clamp_dim(a_cols_q);
	assign br = clamp_dim(b_rows_q);
	assign bc = clamp_dim(b_cols_q);

	assign a_full = (a_lr_q >= ar);
	assign b_full = (b_lr_q >= br);

	// request decode
	assign cmd_acc  = cmd.valid && cmd.ready;
	assign load_a   = cmd_acc && (cmd.payload.mode == MODE_LOAD_A) && !a_full;
	assign load_b   = cmd_acc && (cmd.payload.mode == MODE_LOAD_B) && !b_full;
	assign prod_req = cmd_acc && (cmd.payload.mode == MODE_PRODUCT);

	// status of a product request, mismatch checked first
	always_comb begin
		if (ac != br) begin
			status_d = STATUS_MISMATCH;
		end else if (!a_full || !b_full) begin
			status_d = STATUS_NOT_LOADED;
		end else begin
			status_d = STATUS_OK;
		end
	end

	// store addresses, row-major with a row pitch of MAX_DIM
	assign a_waddr = ADDR_W'(int'(a_lr_q) * MAX_DIM + int'(a_lc_q));
	assign b_waddr = ADDR_W'(int'(b_lr_q) * MAX_DIM + int'(b_lc_q));
	assign a_raddr = ADDR_W'(int'(next_row_q) * MAX_DIM + int'(k_q));
	assign b_raddr = ADDR_W'(int'(k_q) * MAX_DIM + int'(next_col_q));

	assign k_last   = (DIM_W'(k_q) + DIM_W'(1)) >= ac;
	assign pos_last = ((DIM_W'(next_row_q) + DIM_W'(1)) >= ar) &&
		((DIM_W'(next_col_q) + DIM_W'(1)) >= bc);
	assign col_wrap = (DIM_W'(next_col_q) + DIM_W'(1)) >= bc;
	assign res_free = !out_valid_q || res.ready;

	imm_ram #(.DEPTH(DEPTH), .WIDTH(DATA_W)) u_store_a (
		.clk   (clk),
		.we    (load_a),
		.waddr (a_waddr),
		.wdata (cmd.payload.element_value),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	imm_ram #(.DEPTH(DEPTH), .WIDTH(DATA_W)) u_store_b (
		.clk   (clk),
		.we    (load_b),
		.waddr (b_waddr),
		.wdata (cmd.payload.element_value),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	imm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.a      (a_rdata),
		.b      (b_rdata),
		.stat   (mac_stat),
		.acc    (acc)
	);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (prod_req) begin
					state_d = (status_d == STATUS_OK) ? ST_RUN : ST_DONE;
				end
			end
			ST_RUN: begin
				if (k_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!mac_stat.busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd.ready      = 1'b0;
		mac_ctrl.clear = 1'b0;
		mac_ctrl.issue = 1'b0;
		res_load       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.ready      = 1'b1;
				mac_ctrl.clear = prod_req;
			end
			ST_RUN: begin
				mac_ctrl.issue = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_DONE: begin
				res_load = res_free;
			end
			default: begin
			end
		endcase
	end

	// state and term counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			status_q <= STATUS_OK;
			k_q      <= '0;
		end else begin
			state_q <= state_d;
			if (prod_req) begin
				status_q <= status_d;
				k_q      <= '0;
			end else if (state_q == ST_RUN) begin
				k_q <= k_q + IDX_W'(1);
			end
		end
	end

	// size registers, load pointers and product position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q   <= CFG_W'(2);
			a_cols_q   <= CFG_W'(2);
			b_rows_q   <= CFG_W'(2);
			b_cols_q   <= CFG_W'(2);
			a_lr_q     <= '0;
			a_lc_q     <= '0;
			b_lr_q     <= '0;
			b_lc_q     <= '0;
			next_row_q <= '0;
			next_col_q <= '0;
		end else begin
			if (load_a) begin
				if ((DIM_W'(a_lc_q) + DIM_W'(1)) >= ac) begin
					a_lc_q <= '0;
					a_lr_q <= a_lr_q + DIM_W'(1);
				end else begin
					a_lc_q <= a_lc_q + IDX_W'(1);
				end
			end
			if (load_b) begin
				if ((DIM_W'(b_lc_q) + DIM_W'(1)) >= bc) begin
					b_lc_q <= '0;
					b_lr_q <= b_lr_q + DIM_W'(1);
				end else begin
					b_lc_q <= b_lc_q + IDX_W'(1);
				end
			end
			// advance after a good element; the final one starts a new job
			if (res_load && (status_q == STATUS_OK)) begin
				if (pos_last) begin
					a_lr_q     <= '0;
					a_lc_q     <= '0;
					b_lr_q     <= '0;
					b_lc_q     <= '0;
					next_row_q <= '0;
					next_col_q <= '0;
				end else if (col_wrap) begin
					next_col_q <= '0;
					next_row_q <= next_row_q + IDX_W'(1);
				end else begin
					next_col_q <= next_col_q + IDX_W'(1);
				end
			end
			// any size write starts the job over
			if (cfg_we) begin
				case (cfg_index)
					CFG_A_ROWS: a_rows_q <= cfg_data;
					CFG_A_COLS: a_cols_q <= cfg_data;
					CFG_B_ROWS: b_rows_q <= cfg_data;
					CFG_B_COLS: b_cols_q <= cfg_data;
					default: begin
					end
				endcase
				a_lr_q     <= '0;
				a_lc_q     <= '0;
				b_lr_q     <= '0;
				b_lc_q     <= '0;
				next_row_q <= '0;
				next_col_q <= '0;
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload, fields zero on a bad status
	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q.status <= status_q;
			if (status_q == STATUS_OK) begin
				out_q.product_value <= acc;
				out_q.row_index     <= POS_W'(next_row_q);
				out_q.col_index     <= POS_W'(next_col_q);
				out_q.last_element  <= pos_last;
			end else begin
				out_q.product_value <= '0;
				out_q.row_index     <= '0;
				out_q.col_index     <= '0;
				out_q.last_element  <= 1'b0;
			end
		end
	end

	assign res.valid   = out_valid_q;
	assign res.payload = out_q;

endmodule

FILE: rtl/core/imm_ram.sv
`timescale 1ns / 1ps
// imm_ram: one write port, one read port memory with registered read data
// no dependencies

module imm_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/imm_mac.sv
`timescale 1ns / 1ps
// imm_mac: shared multiply-accumulate unit, one term per issued read
// depends on imm_pkg (mac_ctrl_t, mac_stat_t, DATA_W)

module imm_mac import imm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mac_ctrl_t         ctrl,
	input  logic [DATA_W-1:0] a,
	input  logic [DATA_W-1:0] b,
	output mac_stat_t         stat,
	output logic [DATA_W-1:0] acc
);

	logic              rd_s1;
	logic              mul_s2;
	logic [DATA_W-1:0] prod_d;
	logic [DATA_W-1:0] prod_s2;
	logic [DATA_W-1:0] acc_q;

	// low half of the product is all that survives the wrap
	assign prod_d = a * b;

	// term valid pipeline: read data, then product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1  <= 1'b0;
			mul_s2 <= 1'b0;
		end else begin
			rd_s1  <= ctrl.issue;
			mul_s2 <= rd_s1;
		end
	end

	// product register and accumulator
	always_ff @(posedge clk) begin
		if (rd_s1) begin
			prod_s2 <= prod_d;
		end
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (mul_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	assign stat.busy = rd_s1 | mul_s2;
	assign acc       = acc_q;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench of integer_matrix_multiply_unit, loads and product requests
// depends on imm_pkg, imm_stream_if and the unit itself, with its imm_ram and imm_mac

module tb;
	import imm_pkg::*;

	localparam int MAX_DIM       = 8;
	localparam int STORE_DEPTH   = MAX_DIM * MAX_DIM;
	localparam int ITEM_TARGET   = 1550;
	localparam int HOLD_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 20;
	localparam int IDLE_LIMIT    = 2000;
	localparam int REPORT_MAX    = 10;
	// the one mode code that the unit ignores
	localparam mode_t MODE_UNUSED = mode_t'(2'd3);

	// golden product predictor and the queue of product elements still owed
	class product_ledger;
		logic [DATA_W-1:0] a_mem [STORE_DEPTH];
		logic [DATA_W-1:0] b_mem [STORE_DEPTH];
		logic [CFG_W-1:0]  size_reg [4];
		int unsigned       a_count, b_count, row_pos, col_pos;
		res_payload_t      owed [$];
		int unsigned       errors, loads_stored, ignored, requests, rejected;
		int unsigned       checked, jobs_done, reg_writes, effective_items;

		function new();
			foreach (size_reg[i]) size_reg[i] = 4'd2;
			clear_job();
		endfunction

		function void clear_job();
			a_count = 0;
			b_count = 0;
			row_pos = 0;
			col_pos = 0;
		endfunction

		// size registers out of range saturate to the legal span
		function int unsigned eff_dim(logic [CFG_W-1:0] v);
			if (v < 2) return 2;
			if (v > MAX_DIM) return MAX_DIM;
			return 32'(v);
		endfunction

		function void set_size_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
			size_reg[idx] = v;
			reg_writes++;
			clear_job();
		endfunction

		function int unsigned pending();
			return owed.size();
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= REPORT_MAX) $display("mismatch: %s", msg);
		endfunction

		function void take_command(cmd_payload_t c);
			int unsigned ar, ac, br, bc;
			logic [DATA_W-1:0] acc;
			res_payload_t want;
			ar = eff_dim(size_reg[CFG_A_ROWS]);
			ac = eff_dim(size_reg[CFG_A_COLS]);
			br = eff_dim(size_reg[CFG_B_ROWS]);
			bc = eff_dim(size_reg[CFG_B_COLS]);
			case (c.mode)
			MODE_LOAD_A: begin
				if (a_count < ar * ac) begin
					a_mem[(a_count / ac) * MAX_DIM + a_count % ac] = c.element_value;
					a_count++;
					loads_stored++;
					effective_items++;
				end else begin
					ignored++;
				end
			end
			MODE_LOAD_B: begin
				if (b_count < br * bc) begin
					b_mem[(b_count / bc) * MAX_DIM + b_count % bc] = c.element_value;
					b_count++;
					loads_stored++;
					effective_items++;
				end else begin
					ignored++;
				end
			end
			MODE_PRODUCT: begin
				want = '0;
				effective_items++;
				if (ac != br) begin
					want.status = STATUS_MISMATCH;
					rejected++;
				end else if (a_count < ar * ac || b_count < br * bc) begin
					want.status = STATUS_NOT_LOADED;
					rejected++;
				end else begin
					// dot product of row and column, wrapping at the data width
					acc = '0;
					for (int k = 0; k < ac; k++)
						acc = acc + a_mem[row_pos * MAX_DIM + k] * b_mem[k * MAX_DIM + col_pos];
					want.product_value = acc;
					want.row_index     = row_pos[POS_W-1:0];
					want.col_index     = col_pos[POS_W-1:0];
					want.last_element  = (row_pos + 1 >= ar) && (col_pos + 1 >= bc);
					want.status        = STATUS_OK;
					if (want.last_element) begin
						clear_job();
						jobs_done++;
					end else if (col_pos + 1 >= bc) begin
						col_pos = 0;
						row_pos++;
					end else begin
						col_pos++;
					end
				end
				requests++;
				owed.push_back(want);
			end
			default: ignored++;
			endcase
		endfunction

		function void match_product(res_payload_t got);
			res_payload_t want;
			checked++;
			if (owed.size() == 0) begin
				flag($sformatf("unexpected result: value %0d row %0d col %0d last %0d status %0d",
					got.product_value, got.row_index, got.col_index, got.last_element,
					got.status));
				return;
			end
			want = owed.pop_front();
			if (got.product_value !== want.product_value || got.row_index !== want.row_index ||
			    got.col_index !== want.col_index || got.last_element !== want.last_element ||
			    got.status !== want.status)
				flag($sformatf({"result %0d: expected value %0d row %0d col %0d last %0d ",
					"status %0d, got value %0d row %0d col %0d last %0d status %0d"},
					checked, want.product_value, want.row_index, want.col_index,
					want.last_element, want.status, got.product_value, got.row_index,
					got.col_index, got.last_element, got.status));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic [CFG_W-1:0]     cur_cfg [4];
	bit                   no_idle;
	bit                   hold_request;
	int unsigned          idle_cycles;

	product_ledger sb = new();

	imm_stream_if #(.payload_t(cmd_payload_t)) cmd_ch ();
	imm_stream_if #(.payload_t(res_payload_t)) res_ch ();

	integer_matrix_multiply_unit #(.MAX_DIM(MAX_DIM)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// monitor: requests, results and register writes as seen at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) sb.set_size_reg(cfg_reg_t'(cfg_index), cfg_data);
			if (cmd_ch.valid && cmd_ch.ready) sb.take_command(cmd_ch.payload);
			if (res_ch.valid && res_ch.ready) sb.match_product(res_ch.payload);
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// watchdog on cycles with no request and no result moving
	initial begin
		idle_cycles = 0;
		wait (idle_cycles >= IDLE_LIMIT);
		$display("integer_matrix_multiply_unit test failed");
		$finish;
	end

	// result side: random back-pressure, plus the long hold-off on demand
	initial begin : result_sink
		int gap;
		res_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			if (hold_request) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
				res_ch.ready <= 1'b1;
			end else begin
				gap = no_idle ? 0 : $urandom_range(0, 11);
				if (gap > 0) begin
					res_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				res_ch.ready <= 1'b1;
			end
			do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
		end
	end

	function automatic logic [DATA_W-1:0] rand_element();
		logic [DATA_W-1:0] v;
		case ($urandom_range(0, 7))
		0: begin
			case ($urandom_range(0, 4))
			0: v = 32'h7fff_ffff;
			1: v = 32'h8000_0000;
			2: v = '0;
			3: v = '1;
			default: v = 32'd1;
			endcase
		end
		1, 2: v = int'($urandom_range(0, 16)) - 8;
		default: v = $urandom;
		endcase
		return v;
	endfunction

	// raw size value: mostly small, sometimes the largest or out of range
	function automatic logic [CFG_W-1:0] pick_dim();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return CFG_W'($urandom_range(0, 1));
		if (r == 1) return CFG_W'(MAX_DIM);
		if (r == 2) return CFG_W'($urandom_range(MAX_DIM + 1, 15));
		if (r <= 4) return CFG_W'($urandom_range(5, MAX_DIM - 1));
		return CFG_W'($urandom_range(2, 4));
	endfunction

	// b_rows value for a given a_cols: equal in effect, or forced different
	function automatic logic [CFG_W-1:0] pick_partner(logic [CFG_W-1:0] ac, bit differ);
		logic [CFG_W-1:0] b;
		if (differ) begin
			do b = pick_dim(); while (sb.eff_dim(b) == sb.eff_dim(ac));
			return b;
		end
		if ($urandom_range(0, 2) == 0) begin
			if (sb.eff_dim(ac) == 2) return CFG_W'($urandom_range(0, 2));
			if (sb.eff_dim(ac) == MAX_DIM) return CFG_W'($urandom_range(MAX_DIM, 15));
		end
		return ac;
	endfunction

	// offer one request after a random gap and hold it until accepted
	task automatic offer(mode_t m, logic [DATA_W-1:0] v);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.payload <= '{mode: m, element_value: v};
		do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
	endtask

	// stop sending and let every owed result arrive, then let loads settle
	task automatic wait_quiet();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cur_cfg[idx] = v;
	endtask

	task automatic configure(logic [CFG_W-1:0] ar, ac, br, bc, logic [3:0] mask);
		if (mask[CFG_A_ROWS]) write_reg(CFG_A_ROWS, ar);
		if (mask[CFG_A_COLS]) write_reg(CFG_A_COLS, ac);
		if (mask[CFG_B_ROWS]) write_reg(CFG_B_ROWS, br);
		if (mask[CFG_B_COLS]) write_reg(CFG_B_COLS, bc);
		cfg_we <= 1'b0;
	endtask

	// one job: both matrices in row-major order, interleaved, then the products
	task automatic run_job(int unsigned ar, ac, br, bc, int cut, bit noisy, bit squeeze);
		int unsigned a_left, b_left, n_req;
		bit saved;
		a_left = ar * ac;
		b_left = br * bc;
		n_req  = ar * bc;
		saved  = no_idle;
		if (cut >= 0 && cut < int'(n_req)) n_req = cut;
		while (a_left + b_left > 0) begin
			// early request or unused mode while loading
			if (noisy && $urandom_range(0, 15) == 0)
				offer($urandom_range(0, 1) ? MODE_PRODUCT : MODE_UNUSED, $urandom);
			if ($urandom_range(1, a_left + b_left) <= a_left) begin
				offer(MODE_LOAD_A, rand_element());
				a_left--;
			end else begin
				offer(MODE_LOAD_B, rand_element());
				b_left--;
			end
		end
		// loads past the set size are dropped
		if (noisy)
			repeat ($urandom_range(1, 2))
				offer($urandom_range(0, 1) ? MODE_LOAD_A : MODE_LOAD_B, $urandom);
		if (squeeze) begin
			hold_request = 1'b1;
			no_idle      = 1'b1;
		end
		repeat (n_req) offer(MODE_PRODUCT, $urandom);
		// request right after the job cleared
		if (noisy && n_req == ar * bc) offer(MODE_PRODUCT, $urandom);
		no_idle = saved;
	endtask

	// requests while a_cols and b_rows disagree, mixed with loads
	task automatic mismatch_burst();
		offer(MODE_PRODUCT, $urandom);
		repeat ($urandom_range(2, 5)) begin
			case ($urandom_range(0, 2))
			0: offer(MODE_PRODUCT, $urandom);
			1: offer(MODE_LOAD_A, rand_element());
			default: offer(MODE_LOAD_B, rand_element());
			endcase
		end
	endtask

	initial begin : stimulus
		int phase, jobs, cut;
		logic [CFG_W-1:0] ar, ac, br, bc;
		logic [3:0] mask;
		bit differ;

		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_index      <= '0;
		cfg_data       <= '0;
		cmd_ch.valid   <= 1'b0;
		cmd_ch.payload <= '0;
		no_idle        = 1'b0;
		hold_request   = 1'b0;
		foreach (cur_cfg[i]) cur_cfg[i] = 4'd2;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset sizes are 2x2 by 2x2
		offer(MODE_PRODUCT, '0);
		offer(MODE_UNUSED, 32'hdead_beef);
		offer(MODE_LOAD_A, 32'h7fff_ffff);
		offer(MODE_LOAD_A, 32'h8000_0000);
		offer(MODE_LOAD_A, 32'hffff_ffff);
		offer(MODE_LOAD_A, 32'h0000_0000);
		offer(MODE_LOAD_B, 32'h8000_0000);
		offer(MODE_LOAD_B, 32'h7fff_ffff);
		offer(MODE_LOAD_B, 32'h0000_0001);
		offer(MODE_LOAD_B, 32'hffff_ffff);
		offer(MODE_LOAD_A, 32'h1234_5678);
		offer(MODE_LOAD_B, 32'h8765_4321);
		repeat (4) offer(MODE_PRODUCT, '0);
		offer(MODE_PRODUCT, '1);
		wait_quiet();
		// directed: a_cols no longer matches b_rows
		configure(4'd2, 4'd3, 4'd2, 4'd2, 4'b0010);
		offer(MODE_PRODUCT, '0);
		offer(MODE_LOAD_A, 32'h5555_aaaa);

		// random phases: new sizes, then one or more jobs
		phase = 0;
		while (sb.effective_items < ITEM_TARGET) begin
			wait_quiet();
			differ = 1'b0;
			if (phase == 0) begin
				{ar, ac, br, bc} = {4'd15, 4'd8, 4'd8, 4'd15};
				mask = '1;
			end else if (phase == 1) begin
				{ar, ac, br, bc} = {4'd0, 4'd1, 4'd0, 4'd1};
				mask = '1;
			end else begin
				ar     = pick_dim();
				ac     = pick_dim();
				bc     = pick_dim();
				differ = ($urandom_range(0, 7) == 0);
				br     = pick_partner(ac, differ);
				mask   = 4'($urandom_range(0, 15));
				mask[CFG_A_ROWS] |= (ar != cur_cfg[CFG_A_ROWS]);
				mask[CFG_A_COLS] |= (ac != cur_cfg[CFG_A_COLS]);
				mask[CFG_B_ROWS] |= (br != cur_cfg[CFG_B_ROWS]);
				mask[CFG_B_COLS] |= (bc != cur_cfg[CFG_B_COLS]);
				if (mask == '0) mask[$urandom_range(0, 3)] = 1'b1;
			end
			configure(ar, ac, br, bc, mask);
			no_idle = ($urandom_range(0, 4) == 0);
			if (differ) begin
				mismatch_burst();
			end else begin
				jobs = $urandom_range(1, 3);
				for (int j = 0; j < jobs; j++) begin
					cut = -1;
					if (j == jobs - 1 && $urandom_range(0, 5) == 0)
						cut = $urandom_range(0, sb.eff_dim(ar) * sb.eff_dim(bc) - 1);
					run_job(sb.eff_dim(ar), sb.eff_dim(ac), sb.eff_dim(br), sb.eff_dim(bc),
						cut, $urandom_range(0, 3) == 0,
						(phase == 2 && j == 0) || $urandom_range(0, 11) == 0);
				end
			end
			phase++;
		end
		no_idle = 1'b0;
		wait_quiet();

		$display("summary: %0d elements loaded, %0d product requests, %0d rejected by status",
			sb.loads_stored, sb.requests, sb.rejected);
		$display("summary: %0d ignored items, %0d jobs finished, %0d register writes, %0d errors",
			sb.ignored, sb.jobs_done, sb.reg_writes, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("integer_matrix_multiply_unit test passed");
		else
			$display("integer_matrix_multiply_unit test failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/imm_pkg.sv
rtl/core/imm_stream_if.sv
rtl/core/imm_ram.sv
rtl/core/imm_mac.sv
rtl/core/integer_matrix_multiply_unit.sv
sim/tb.sv
